// ===== sv/qslerp_pkg.sv =====
// ----------------------------------------------------------------------------
// qslerp_pkg
// Shared types and constants of the quaternion slerp pipeline.
// ----------------------------------------------------------------------------
package qslerp_pkg;

    localparam int FIELD_W   = 16;
    localparam int BLEND_W   = 15;
    localparam int FRAC_BITS = 14;
    localparam int ONE_Q14   = 16384;
    localparam int STEPS     = 16;
    localparam int THR_RESET = 16382;
    localparam logic signed [31:0] INV_GAIN_Q28 = 32'sd163008218;

    typedef struct packed {
        logic signed [FIELD_W-1:0] first_w;
        logic signed [FIELD_W-1:0] first_x;
        logic signed [FIELD_W-1:0] first_y;
        logic signed [FIELD_W-1:0] first_z;
        logic signed [FIELD_W-1:0] second_w;
        logic signed [FIELD_W-1:0] second_x;
        logic signed [FIELD_W-1:0] second_y;
        logic signed [FIELD_W-1:0] second_z;
        logic        [BLEND_W-1:0] blend;
    } t_in_beat;

    typedef struct packed {
        logic signed [FIELD_W-1:0] out_w;
        logic signed [FIELD_W-1:0] out_x;
        logic signed [FIELD_W-1:0] out_y;
        logic signed [FIELD_W-1:0] out_z;
    } t_out_beat;

    // Arctangent table in Q.16
    function automatic logic signed [17:0] atan_q16(input logic [3:0] i);
        logic signed [17:0] v;
        unique case (i)
            4'd0:  v = 18'sd51472;
            4'd1:  v = 18'sd30386;
            4'd2:  v = 18'sd16055;
            4'd3:  v = 18'sd8150;
            4'd4:  v = 18'sd4091;
            4'd5:  v = 18'sd2047;
            4'd6:  v = 18'sd1024;
            4'd7:  v = 18'sd512;
            4'd8:  v = 18'sd256;
            4'd9:  v = 18'sd128;
            4'd10: v = 18'sd64;
            4'd11: v = 18'sd32;
            4'd12: v = 18'sd16;
            4'd13: v = 18'sd8;
            4'd14: v = 18'sd4;
            default: v = 18'sd2;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/quaternion_slerp.sv =====
// Quaternion slerp, fully pipelined: one pair enters every cycle.
// Stages on the path from the start edge to the edge that takes the o_done beat:
// dot, 15-step square root, 16-step angle CORDIC, two 16-step sine CORDICs,
// two 16-bit dividers. Throughput: one beat per cycle; busy stays low since
// the receiver cannot stall. Synchronous active-low reset clears valid bits,
// loads THR_RESET into the threshold register; payload registers hold no reset.
// ----------------------------------------------------------------------------
// quaternion_slerp
// Spherical linear interpolation of two Q1.14 quaternions with saturation.
// ----------------------------------------------------------------------------
module quaternion_slerp import qslerp_pkg::*; #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  t_in_beat        i_in,
    output logic            o_done,
    output t_out_beat       o_out,
    input  logic            i_cfg_we,
    input  logic [BLEND_W-1:0] i_cfg_data
);
    localparam int OB   = (COMPONENT_WIDTH < FIELD_W) ? COMPONENT_WIDTH : FIELD_W;
    localparam int SQ_N = 15;   // result bits of the root
    localparam int DV_N = 16;   // quotient bits of each divider
    localparam int LAT  = 1 + 1 + SQ_N + 1 + STEPS + 1 + STEPS + 1 + DV_N + 1 + 1;
    localparam logic signed [FIELD_W+1:0] HI = (FIELD_W+2)'((1 << (OB-1)) - 1);
    localparam logic signed [FIELD_W+1:0] LO = -HI - 1;

    typedef struct packed {
        logic signed [3:0][FIELD_W-1:0] a;
        logic signed [3:0][FIELD_W:0]   b;
    } t_quat;

    logic [BLEND_W-1:0] r_thr;
    logic [LAT-1:0]     r_vld;
    assign busy = 1'b0;

    // Hold the threshold register and shift the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= BLEND_W'(THR_RESET);
            r_vld <= '0;
        end else begin
            if (i_cfg_we) r_thr <= i_cfg_data;
            r_vld <= {r_vld[LAT-2:0], start};
        end
    end

    // Sign-extend components from COMPONENT_WIDTH
    function automatic logic signed [FIELD_W-1:0] sx(input logic [FIELD_W-1:0] v);
        logic [FIELD_W-1:0] r;
        for (int k = 0; k < FIELD_W; k++)
            r[k] = (k < OB) ? v[k] : v[OB-1];
        return r;
    endfunction

    // Stage 1: products of the dot, blend clamped to one
    t_quat r1_q; logic [BLEND_W-1:0] r1_t;
    logic signed [3:0][31:0] r1_p;
    always_ff @(posedge i_clk) begin
        r1_q.a <= {sx(i_in.first_w), sx(i_in.first_x), sx(i_in.first_y), sx(i_in.first_z)};
        r1_q.b[3] <= (FIELD_W+1)'(sx(i_in.second_w));
        r1_q.b[2] <= (FIELD_W+1)'(sx(i_in.second_x));
        r1_q.b[1] <= (FIELD_W+1)'(sx(i_in.second_y));
        r1_q.b[0] <= (FIELD_W+1)'(sx(i_in.second_z));
        r1_t   <= (i_in.blend > BLEND_W'(ONE_Q14)) ? BLEND_W'(ONE_Q14) : i_in.blend;
        r1_p[3] <= 32'(sx(i_in.first_w)) * 32'(sx(i_in.second_w));
        r1_p[2] <= 32'(sx(i_in.first_x)) * 32'(sx(i_in.second_x));
        r1_p[1] <= 32'(sx(i_in.first_y)) * 32'(sx(i_in.second_y));
        r1_p[0] <= 32'(sx(i_in.first_z)) * 32'(sx(i_in.second_z));
    end

    // Stage 2: sum, flip to short arc, cosine, path choice
    logic signed [33:0] dot;
    logic [33:0] adot;
    logic [19:0] c20;
    assign dot  = 34'(signed'(r1_p[0])) + 34'(signed'(r1_p[1]))
                + 34'(signed'(r1_p[2])) + 34'(signed'(r1_p[3]));
    assign adot = dot[33] ? 34'(-dot) : dot;
    assign c20  = adot[33:14];
    t_quat r2_q; logic [BLEND_W-1:0] r2_t, r2_c; logic r2_lin;
    always_ff @(posedge i_clk) begin
        r2_q.a <= r1_q.a;
        for (int k = 0; k < 4; k++)
            r2_q.b[k] <= dot[33] ? (FIELD_W+1)'(-r1_q.b[k]) : r1_q.b[k];
        r2_t   <= r1_t;
        r2_c   <= (c20 >= 20'(ONE_Q14)) ? BLEND_W'(ONE_Q14) : BLEND_W'(c20);
        r2_lin <= (c20 >= 20'(ONE_Q14)) || (c20 > 20'(r_thr));
    end

    // Root stages: sin = isqrt(2^28 - c^2), one result bit a stage
    logic [SQ_N:0][28:0] sq_rem;
    logic [SQ_N:0][14:0] sq_res;
    t_quat       sq_q [SQ_N+1];
    logic [BLEND_W-1:0] sq_t [SQ_N+1], sq_c [SQ_N+1];
    logic [SQ_N:0] sq_lin;
    assign sq_rem[0] = 29'(1 << 28) - 29'(r2_c) * 29'(r2_c);
    assign sq_res[0] = '0;
    assign sq_q[0] = r2_q; assign sq_t[0] = r2_t; assign sq_c[0] = r2_c;
    assign sq_lin[0] = r2_lin;
    for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
        localparam int B = SQ_N - 1 - g;
        logic [30:0] trial;
        // Growth of the square when bit B joins the root
        assign trial = (31'(sq_res[g]) << (B + 1)) + (31'(1) << (2 * B));
        always_ff @(posedge i_clk) begin
            if (31'(sq_rem[g]) >= trial) begin
                sq_rem[g+1] <= 29'(31'(sq_rem[g]) - trial);
                sq_res[g+1] <= sq_res[g] | 15'(1 << B);
            end else begin
                sq_rem[g+1] <= sq_rem[g];
                sq_res[g+1] <= sq_res[g];
            end
            sq_q[g+1] <= sq_q[g]; sq_t[g+1] <= sq_t[g]; sq_c[g+1] <= sq_c[g];
            sq_lin[g+1] <= sq_lin[g];
        end
    end

    // Register the root; zero sine forces linear weights
    logic [14:0] r3_s; t_quat r3_q; logic [BLEND_W-1:0] r3_t, r3_c; logic r3_lin;
    always_ff @(posedge i_clk) begin
        r3_s <= sq_res[SQ_N]; r3_q <= sq_q[SQ_N]; r3_t <= sq_t[SQ_N];
        r3_c <= sq_c[SQ_N];
        r3_lin <= sq_lin[SQ_N] || (sq_res[SQ_N] == '0);
    end

    // Angle CORDIC, vectoring: w = atan2(s, c)
    logic signed [STEPS:0][31:0] va_x, va_y;
    logic signed [STEPS:0][19:0] va_z;
    logic [14:0] va_s [STEPS+1]; t_quat va_q [STEPS+1];
    logic [BLEND_W-1:0] va_t [STEPS+1]; logic [STEPS:0] va_lin;
    assign va_x[0] = 32'({r3_c, 14'b0}); assign va_y[0] = 32'({r3_s, 14'b0});
    assign va_z[0] = '0;
    assign va_s[0] = r3_s; assign va_q[0] = r3_q; assign va_t[0] = r3_t;
    assign va_lin[0] = r3_lin;
    for (genvar g = 0; g < STEPS; g++) begin : g_vec
        qslerp_cordic_stage #(.STEP(g), .VECTOR(1'b1)) u_st (
            .i_clk(i_clk), .i_x(va_x[g]), .i_y(va_y[g]), .i_z(va_z[g]),
            .o_x(va_x[g+1]), .o_y(va_y[g+1]), .o_z(va_z[g+1]));
        always_ff @(posedge i_clk) begin
            va_s[g+1] <= va_s[g]; va_q[g+1] <= va_q[g]; va_t[g+1] <= va_t[g];
            va_lin[g+1] <= va_lin[g];
        end
    end

    // Scale the angle by 1-t and t
    logic [18:0] w_pos;
    assign w_pos = va_z[STEPS][19] ? '0 : va_z[STEPS][18:0];
    logic signed [19:0] r4_th0, r4_th1; logic [14:0] r4_s; t_quat r4_q;
    logic [BLEND_W-1:0] r4_t; logic r4_lin;
    always_ff @(posedge i_clk) begin
        r4_th0 <= 20'((34'(BLEND_W'(ONE_Q14) - va_t[STEPS]) * 34'(w_pos)) >> 14);
        r4_th1 <= 20'((34'(va_t[STEPS]) * 34'(w_pos)) >> 14);
        r4_s <= va_s[STEPS]; r4_q <= va_q[STEPS]; r4_t <= va_t[STEPS];
        r4_lin <= va_lin[STEPS];
    end

    // Two sine CORDICs, rotation mode
    logic signed [1:0][STEPS:0][31:0] ro_x, ro_y;
    logic signed [1:0][STEPS:0][19:0] ro_z;
    logic [14:0] ro_s [STEPS+1]; t_quat ro_q [STEPS+1];
    logic [BLEND_W-1:0] ro_t [STEPS+1]; logic [STEPS:0] ro_lin;
    assign ro_x[0][0] = INV_GAIN_Q28; assign ro_y[0][0] = '0; assign ro_z[0][0] = r4_th0;
    assign ro_x[1][0] = INV_GAIN_Q28; assign ro_y[1][0] = '0; assign ro_z[1][0] = r4_th1;
    assign ro_s[0] = r4_s; assign ro_q[0] = r4_q; assign ro_t[0] = r4_t;
    assign ro_lin[0] = r4_lin;
    for (genvar g = 0; g < STEPS; g++) begin : g_rot
        for (genvar h = 0; h < 2; h++) begin : g_lane
            qslerp_cordic_stage #(.STEP(g), .VECTOR(1'b0)) u_st (
                .i_clk(i_clk), .i_x(ro_x[h][g]), .i_y(ro_y[h][g]), .i_z(ro_z[h][g]),
                .o_x(ro_x[h][g+1]), .o_y(ro_y[h][g+1]), .o_z(ro_z[h][g+1]));
        end
        always_ff @(posedge i_clk) begin
            ro_s[g+1] <= ro_s[g]; ro_q[g+1] <= ro_q[g]; ro_t[g+1] <= ro_t[g];
            ro_lin[g+1] <= ro_lin[g];
        end
    end

    // Clamp sines, add half divisor as numerator
    logic [1:0][29:0] r5_n; logic [14:0] r5_s; t_quat r5_q;
    logic [BLEND_W-1:0] r5_t; logic r5_lin;
    always_ff @(posedge i_clk) begin
        for (int h = 0; h < 2; h++)
            r5_n[h] <= (ro_y[h][STEPS][31] ? 30'd0 : 30'(ro_y[h][STEPS]))
                       + 30'(ro_s[STEPS] >> 1);
        r5_s <= ro_s[STEPS]; r5_q <= ro_q[STEPS]; r5_t <= ro_t[STEPS];
        r5_lin <= ro_lin[STEPS];
    end

    // Restoring dividers, one quotient bit a stage (quotient below 2^16)
    logic [1:0][DV_N:0][29:0] dv_r;
    logic [1:0][DV_N:0][DV_N-1:0] dv_qt;
    logic [14:0] dv_s [DV_N+1]; t_quat dv_q [DV_N+1];
    logic [BLEND_W-1:0] dv_t [DV_N+1]; logic [DV_N:0] dv_lin;
    assign dv_r[0][0] = r5_n[0]; assign dv_r[1][0] = r5_n[1];
    assign dv_qt[0][0] = '0; assign dv_qt[1][0] = '0;
    assign dv_s[0] = r5_s; assign dv_q[0] = r5_q; assign dv_t[0] = r5_t;
    assign dv_lin[0] = r5_lin;
    for (genvar g = 0; g < DV_N; g++) begin : g_div
        localparam int B = DV_N - 1 - g;
        for (genvar h = 0; h < 2; h++) begin : g_lane
            logic [45:0] dsh;
            assign dsh = 46'(dv_s[g]) << B;
            always_ff @(posedge i_clk) begin
                if (46'(dv_r[h][g]) >= dsh) begin
                    dv_r[h][g+1]  <= 30'(46'(dv_r[h][g]) - dsh);
                    dv_qt[h][g+1] <= dv_qt[h][g] | DV_N'(1 << B);
                end else begin
                    dv_r[h][g+1]  <= dv_r[h][g];
                    dv_qt[h][g+1] <= dv_qt[h][g];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            dv_s[g+1] <= dv_s[g]; dv_q[g+1] <= dv_q[g]; dv_t[g+1] <= dv_t[g];
            dv_lin[g+1] <= dv_lin[g];
        end
    end

    // Select weights and multiply
    logic [16:0] k0, k1;
    assign k0 = dv_lin[DV_N] ? 17'(BLEND_W'(ONE_Q14) - dv_t[DV_N]) : 17'(dv_qt[0][DV_N]);
    assign k1 = dv_lin[DV_N] ? 17'(dv_t[DV_N]) : 17'(dv_qt[1][DV_N]);
    logic signed [3:0][33:0] r6_pa, r6_pb;
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r6_pa[k] <= 34'(signed'(dv_q[DV_N].a[k])) * 34'(signed'({1'b0, k0}));
            r6_pb[k] <= 34'(signed'(dv_q[DV_N].b[k])) * 34'(signed'({1'b0, k1}));
        end
    end

    // Round, shift, saturate
    logic signed [3:0][FIELD_W-1:0] res;
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            logic signed [34:0] sm;
            logic signed [20:0] v;
            sm = 35'(signed'(r6_pa[k])) + 35'(signed'(r6_pb[k])) + 35'sd8192;
            v  = 21'(sm >>> 14);
            if (v > 21'(HI))      res[k] = FIELD_W'(HI);
            else if (v < 21'(LO)) res[k] = FIELD_W'(LO);
            else                  res[k] = FIELD_W'(v);
        end
    end
    always_ff @(posedge i_clk) begin
        o_out <= {res[3], res[2], res[1], res[0]};
    end
    assign o_done = r_vld[LAT-1];
endmodule

// ===== sv/qslerp_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// qslerp_cordic_stage
// One registered CORDIC micro-rotation; vectoring or rotation by parameter.
// ----------------------------------------------------------------------------
module qslerp_cordic_stage import qslerp_pkg::*; #(
    parameter int STEP   = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic               i_clk,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic signed [19:0] i_z,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y,
    output logic signed [19:0] o_z
);
    logic signed [31:0] xs, ys;
    logic               dir;
    logic signed [19:0] at;

    // Shift with floor rounding, pick the direction
    assign xs  = i_x >>> STEP;
    assign ys  = i_y >>> STEP;
    assign at  = 20'(atan_q16(4'(STEP)));
    assign dir = VECTOR ? !i_y[31] : !i_z[19];

    always_ff @(posedge i_clk) begin
        if (dir) begin
            o_x <= VECTOR ? i_x + ys : i_x - ys;
            o_y <= VECTOR ? i_y - xs : i_y + xs;
            o_z <= VECTOR ? i_z + at : i_z - at;
        end else begin
            o_x <= VECTOR ? i_x - ys : i_x + ys;
            o_y <= VECTOR ? i_y + xs : i_y - xs;
            o_z <= VECTOR ? i_z - at : i_z + at;
        end
    end
endmodule
